// ===== hdl/ppi_kcp_pkg.sv =====
// Shared types and constants for the keyboard/cassette parallel port block.
// No dependencies; used by ppi_kcp_keys, ppi_kcp_ctrl and the top module.
package ppi_kcp_pkg;

	// request types
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_LOAD  = 2'd2;

	// port addresses
	localparam logic [1:0] PORT_A    = 2'd0;
	localparam logic [1:0] PORT_B    = 2'd1;
	localparam logic [1:0] PORT_C    = 2'd2;
	localparam logic [1:0] PORT_CTRL = 2'd3;

	// configuration register indexes
	localparam logic CFG_MODEL    = 1'b0;
	localparam logic CFG_PRESCALE = 1'b1;

	localparam logic [7:0] PRESCALE_RST = 8'd50;
	localparam logic [7:0] CTRL_RD_VAL  = 8'hC7;
	localparam logic [7:0] KEYS_NONE    = 8'hFF;
	localparam logic [7:0] SHIFT_CODE_A = 8'hFE;
	localparam logic [7:0] SHIFT_CODE_K = 8'hDF;
	localparam logic [7:0] CTRL_CODE_A  = 8'h7F;

	// keyboard rows with special handling
	localparam int K_SHIFT_ROW = 8;
	localparam int K_AUX_ROW   = 9;
	localparam int A_SHIFT_ROW = 0;

	// port C bit select codes for set/reset control words
	localparam logic [2:0] PC_GATE  = 3'd0;
	localparam logic [2:0] PC_TAPE  = 3'd1;
	localparam logic [2:0] PC_SENSE = 3'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] port_sel;
		logic [7:0] write_data;
		logic [3:0] key_row;
		logic [7:0] key_bits;
		logic       tape_in;
		logic       vblank_in;
	} item_t;

	typedef struct packed {
		logic       load;     // commit a row load
		logic       kbd_read; // commit a port B read (may clear a shift row)
		logic [3:0] row;
		logic [7:0] bits;
		logic [3:0] strobe;
		logic       model;
	} key_cmd_t;

	typedef struct packed {
		logic [7:0] port_a;
		logic [3:0] port_c_low;
		logic       motor;
		logic       blink_msb;
	} ctrl_stat_t;

	typedef struct packed {
		logic tape_valid;
		logic tape_bit;
		logic gate_next;
		logic motor_next;
	} ctrl_res_t;

endpackage

// ===== hdl/ppi_kcp_keys.sv =====
// Keyboard row store: row loads, strobed row read with shift suppression.
// Depends on ppi_kcp_pkg.
module ppi_kcp_keys #(
	parameter int KEY_ROWS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppi_kcp_pkg::key_cmd_t cmd,
	output logic [7:0]           kbd_data
);
	localparam int ROW_W = $clog2(KEY_ROWS);

	logic [7:0] rows_q [KEY_ROWS];
	logic       strobe_ok, load_ok, sh_k, sh_a;
	logic       clr_k, clr_a;
	logic [7:0] raw;

	assign strobe_ok = {1'b0, cmd.strobe} < 5'(KEY_ROWS);
	assign load_ok   = {1'b0, cmd.row} < 5'(KEY_ROWS);
	assign raw       = rows_q[cmd.strobe[ROW_W-1:0]];

	assign sh_k = (rows_q[ROW_W'(ppi_kcp_pkg::K_SHIFT_ROW)] == ppi_kcp_pkg::SHIFT_CODE_A) ||
		(rows_q[ROW_W'(ppi_kcp_pkg::K_SHIFT_ROW)] == ppi_kcp_pkg::SHIFT_CODE_K);
	assign sh_a = (rows_q[ROW_W'(ppi_kcp_pkg::A_SHIFT_ROW)] == ppi_kcp_pkg::SHIFT_CODE_A) ||
		(rows_q[ROW_W'(ppi_kcp_pkg::A_SHIFT_ROW)] == ppi_kcp_pkg::CTRL_CODE_A);

	always_comb begin
		kbd_data = raw;
		clr_k    = 1'b0;
		clr_a    = 1'b0;
		if (!strobe_ok) begin
			kbd_data = ppi_kcp_pkg::KEYS_NONE;
		end else if (!cmd.model) begin
			if (cmd.strobe < 4'(ppi_kcp_pkg::K_SHIFT_ROW)) begin
				if (sh_k) kbd_data = ppi_kcp_pkg::KEYS_NONE;
			end else if (cmd.strobe == 4'(ppi_kcp_pkg::K_SHIFT_ROW)) begin
				// lone shift is consumed once read, unless row 9 has a key down
				clr_k = sh_k &&
					(rows_q[ROW_W'(ppi_kcp_pkg::K_AUX_ROW)] == ppi_kcp_pkg::KEYS_NONE);
			end
		end else begin
			if (cmd.strobe != 4'(ppi_kcp_pkg::A_SHIFT_ROW)) begin
				if (sh_a) kbd_data = ppi_kcp_pkg::KEYS_NONE;
			end else begin
				clr_a = sh_a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_ROWS; i++) rows_q[i] <= ppi_kcp_pkg::KEYS_NONE;
		end else begin
			if (cmd.load && load_ok) begin
				rows_q[cmd.row[ROW_W-1:0]] <= cmd.bits;
			end
			if (cmd.kbd_read && clr_k) begin
				rows_q[ROW_W'(ppi_kcp_pkg::K_SHIFT_ROW)] <= ppi_kcp_pkg::KEYS_NONE;
			end
			if (cmd.kbd_read && clr_a) begin
				rows_q[ROW_W'(ppi_kcp_pkg::A_SHIFT_ROW)] <= ppi_kcp_pkg::KEYS_NONE;
			end
		end
	end

endmodule

// ===== hdl/ppi_kcp_ctrl.sv =====
// Port A/C registers, cursor-blink prescaler, cassette and gate flags.
// Depends on ppi_kcp_pkg.
module ppi_kcp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    commit,
	input  ppi_kcp_pkg::item_t      item,
	input  logic [7:0]              prescale,
	output ppi_kcp_pkg::ctrl_stat_t stat,
	output ppi_kcp_pkg::ctrl_res_t  res
);
	logic [7:0] port_a_q, pre_q, blink_q;
	logic [3:0] pcl_q;
	logic       motor_q, sense_q, gate_q;

	logic [7:0] port_a_d, pre_d, blink_d, pre_inc;
	logic [3:0] pcl_d;
	logic       motor_d, sense_d, gate_d;
	logic       v;
	logic [2:0] bsel;

	assign v       = item.write_data[0];
	assign bsel    = item.write_data[3:1];
	assign pre_inc = pre_q + 8'd1;

	always_comb begin
		port_a_d       = port_a_q;
		pre_d          = pre_q;
		blink_d        = blink_q;
		pcl_d          = pcl_q;
		motor_d        = motor_q;
		sense_d        = sense_q;
		gate_d         = gate_q;
		res.tape_valid = 1'b0;
		res.tape_bit   = 1'b0;
		if (item.req_type == ppi_kcp_pkg::REQ_WRITE) begin
			case (item.port_sel)
				ppi_kcp_pkg::PORT_A: begin
					port_a_d = item.write_data;
					if (item.write_data[7]) begin
						if (pre_inc > prescale) begin
							pre_d   = '0;
							blink_d = blink_q + 8'd1;
						end else begin
							pre_d = pre_inc;
						end
					end
				end
				ppi_kcp_pkg::PORT_C: pcl_d = item.write_data[3:0];
				ppi_kcp_pkg::PORT_CTRL: begin
					// bit 7 clear: single-bit set/reset; mode words are dropped
					if (!item.write_data[7]) begin
						if (!bsel[2]) pcl_d[bsel[1:0]] = v;
						if (bsel == ppi_kcp_pkg::PC_GATE) begin
							gate_d = ~v;
						end else if (bsel == ppi_kcp_pkg::PC_TAPE) begin
							if (sense_q && motor_q) begin
								res.tape_valid = 1'b1;
								res.tape_bit   = v;
							end
						end else if (bsel == ppi_kcp_pkg::PC_SENSE && v) begin
							sense_d = ~sense_q;
							motor_d = ~motor_q;
						end
					end
				end
				default: ;
			endcase
		end
		res.gate_next  = gate_d;
		res.motor_next = motor_d;
	end

	assign stat.port_a     = port_a_q;
	assign stat.port_c_low = pcl_q;
	assign stat.motor      = motor_q;
	assign stat.blink_msb  = blink_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q <= '0;
			pre_q    <= '0;
			blink_q  <= '0;
			pcl_q    <= '0;
			motor_q  <= 1'b1;
			sense_q  <= 1'b1;
			gate_q   <= 1'b0;
		end else if (commit) begin
			port_a_q <= port_a_d;
			pre_q    <= pre_d;
			blink_q  <= blink_d;
			pcl_q    <= pcl_d;
			motor_q  <= motor_d;
			sense_q  <= sense_d;
			gate_q   <= gate_d;
		end
	end

endmodule

// ===== hdl/ppi_keyboard_cassette_port_top.sv =====
// Top level of the keyboard/cassette parallel port block.
// Depends on ppi_kcp_pkg, ppi_kcp_ctrl, ppi_kcp_keys.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | req_type port_sel write_data key_row
//          |                      | key_bits tape_in vblank_in
//  out     | out_valid / out_stall| read_data tape_write_valid tape_write_bit
//          |                      | screen_blank motor_on
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data (ready is always high)
//
// One word per cycle sustained while out_stall is low. A word waits in the
// input register until the output register can take it, and its result is
// then registered there; the port/key logic lies between those two registers.
// While the output is stalled the input register holds one more word, then
// in_stall rises. Reset is asynchronous and leaves the key store all 0xFF.
module ppi_keyboard_cassette_port_top #(
	parameter int KEY_ROWS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [1:0] port_sel,
	input  logic [7:0] write_data,
	input  logic [3:0] key_row,
	input  logic [7:0] key_bits,
	input  logic       tape_in,
	input  logic       vblank_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       tape_write_valid,
	output logic       tape_write_bit,
	output logic       screen_blank,
	output logic       motor_on,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	logic                    model_q;
	logic [7:0]              prescale_q;
	logic                    valid_s1, out_valid_q;
	ppi_kcp_pkg::item_t      item_s1;
	logic                    adv, commit, accept;
	ppi_kcp_pkg::ctrl_stat_t stat;
	ppi_kcp_pkg::ctrl_res_t  res;
	ppi_kcp_pkg::key_cmd_t   kcmd;
	logic [7:0]              kbd_data, rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q    <= 1'b0;
			prescale_q <= ppi_kcp_pkg::PRESCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppi_kcp_pkg::CFG_MODEL:    model_q    <= cfg_data[0];
				ppi_kcp_pkg::CFG_PRESCALE: prescale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register free or being drained this cycle
	assign adv      = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{req_type, port_sel, write_data, key_row, key_bits,
				tape_in, vblank_in};
		end
	end

	ppi_kcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.item     (item_s1),
		.prescale (prescale_q),
		.stat     (stat),
		.res      (res)
	);

	assign kcmd.load     = commit && (item_s1.req_type == ppi_kcp_pkg::REQ_LOAD);
	assign kcmd.kbd_read = commit && (item_s1.req_type == ppi_kcp_pkg::REQ_READ) &&
		(item_s1.port_sel == ppi_kcp_pkg::PORT_B);
	assign kcmd.row      = item_s1.key_row;
	assign kcmd.bits     = item_s1.key_bits;
	assign kcmd.strobe   = stat.port_a[3:0];
	assign kcmd.model    = model_q;

	ppi_kcp_keys #(
		.KEY_ROWS (KEY_ROWS)
	) u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (kcmd),
		.kbd_data (kbd_data)
	);

	always_comb begin
		rd = '0;
		if (item_s1.req_type == ppi_kcp_pkg::REQ_READ) begin
			case (item_s1.port_sel)
				ppi_kcp_pkg::PORT_A: rd = stat.port_a;
				ppi_kcp_pkg::PORT_B: rd = kbd_data;
				ppi_kcp_pkg::PORT_C: rd = {item_s1.vblank_in, stat.blink_msb,
					item_s1.tape_in, stat.motor, stat.port_c_low};
				default:             rd = ppi_kcp_pkg::CTRL_RD_VAL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			read_data        <= rd;
			tape_write_valid <= res.tape_valid;
			tape_write_bit   <= res.tape_bit;
			screen_blank     <= res.gate_next;
			motor_on         <= res.motor_next;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/ppi_kcp_checker.sv =====
// Port-level checks for the keyboard/cassette parallel port block,
// bound to ppi_keyboard_cassette_port_top.
module ppi_kcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       tape_write_valid,
	input logic       tape_write_bit,
	input logic       motor_on
);

	// a tape bit of one is never shown without its valid flag
	a_tape_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tape_write_bit |-> tape_write_valid)
		else $error("tape bit without tape valid");

	// a tape pulse only goes out while the motor is running
	a_tape_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tape_write_valid |-> motor_on)
		else $error("tape pulse with motor off");

	// with the output register empty the input side must be open
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("stalled output word changed");

endmodule

bind ppi_keyboard_cassette_port_top ppi_kcp_checker u_kcp_checker (.*);

// ===== tb/ppi_kcp_tb_pkg.sv =====
`timescale 1ns / 100ps
// Result predictor and scoreboard for the keyboard/cassette port testbench.
// Depends on ppi_kcp_pkg for the word layout and port/control codes.
package ppi_kcp_tb_pkg;
	import ppi_kcp_pkg::*;

	localparam int N_KEY_ROWS = 10;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tape_valid;
		logic       tape_bit;
		logic       screen_blank;
		logic       motor_on;
	} port_result_t;

	class ppi_access_board;
		// shadow of the block's configuration and state
		logic       model;
		logic [7:0] prescale;
		logic [7:0] port_a;
		logic [3:0] pc_low;
		logic [7:0] blink_div;
		logic [7:0] blink_cnt;
		logic       motor;
		logic       sense;
		logic       gate;
		logic [7:0] keys [N_KEY_ROWS];

		port_result_t due[$];
		int misses;

		function new();
			model     = 1'b0;
			prescale  = PRESCALE_RST;
			port_a    = '0;
			pc_low    = '0;
			blink_div = '0;
			blink_cnt = '0;
			motor     = 1'b1;
			sense     = 1'b1;
			gate      = 1'b0;
			foreach (keys[i])
				keys[i] = KEYS_NONE;
			misses = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == CFG_MODEL)
				model = val[0];
			else
				prescale = val;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// port B read: strobed row with shift/ctrl suppression, may clear shift row
		function logic [7:0] scan_keys();
			int         idx;
			logic [7:0] val;
			logic       shifted;
			idx = port_a[3:0];
			if (idx >= N_KEY_ROWS)
				return KEYS_NONE;
			val = keys[idx];
			if (model == 1'b0) begin
				shifted = keys[K_SHIFT_ROW] == SHIFT_CODE_A || keys[K_SHIFT_ROW] == SHIFT_CODE_K;
				if (idx < K_SHIFT_ROW) begin
					if (shifted)
						val = KEYS_NONE;
				end else if (idx == K_SHIFT_ROW && shifted && keys[K_AUX_ROW] == KEYS_NONE) begin
					keys[K_SHIFT_ROW] = KEYS_NONE;
				end
			end else begin
				shifted = keys[A_SHIFT_ROW] == SHIFT_CODE_A || keys[A_SHIFT_ROW] == CTRL_CODE_A;
				if (idx != A_SHIFT_ROW) begin
					if (shifted)
						val = KEYS_NONE;
				end else if (shifted) begin
					keys[A_SHIFT_ROW] = KEYS_NONE;
				end
			end
			return val;
		endfunction

		// accepted input word: advance the shadow state, queue the result
		function void note_word(item_t w);
			port_result_t r;
			logic [2:0]   bsel;
			logic         v;
			r    = '0;
			v    = w.write_data[0];
			bsel = w.write_data[3:1];
			case (w.req_type)
				REQ_WRITE: begin
					case (w.port_sel)
						PORT_A: begin
							if (w.write_data[7]) begin
								blink_div = blink_div + 8'd1;
								if (blink_div > prescale) begin
									blink_div = '0;
									blink_cnt = blink_cnt + 8'd1;
								end
							end
							port_a = w.write_data;
						end
						PORT_C: pc_low = w.write_data[3:0];
						PORT_CTRL: begin
							// bit 7 set is a mode word and is dropped
							if (!w.write_data[7]) begin
								if (bsel < 3'd4)
									pc_low[bsel[1:0]] = v;
								case (bsel)
									PC_GATE: gate = ~v;
									PC_TAPE: begin
										if (sense && motor) begin
											r.tape_valid = 1'b1;
											r.tape_bit   = v;
										end
									end
									PC_SENSE: begin
										if (v) begin
											sense = ~sense;
											motor = ~motor;
										end
									end
									default: ;
								endcase
							end
						end
						default: ;
					endcase
				end
				REQ_READ: begin
					case (w.port_sel)
						PORT_A: r.read_data = port_a;
						PORT_B: r.read_data = scan_keys();
						PORT_C: r.read_data = {w.vblank_in, blink_cnt[7], w.tape_in, motor, pc_low};
						default: r.read_data = CTRL_RD_VAL;
					endcase
				end
				REQ_LOAD: begin
					if (w.key_row < N_KEY_ROWS)
						keys[w.key_row] = w.key_bits;
				end
				default: ;
			endcase
			r.screen_blank = gate;
			r.motor_on     = motor;
			due.push_back(r);
		endfunction

		function void log_miss(string what, logic [7:0] want, logic [7:0] got);
			if (misses < 10)
				$display("mismatch %0d: %s expected %h got %h", misses + 1, what, want, got);
			misses++;
		endfunction

		function void check_word(port_result_t got);
			port_result_t want;
			if (due.size() == 0) begin
				log_miss("result word with nothing pending, read_data", 8'h00, got.read_data);
				return;
			end
			want = due.pop_front();
			if (got.read_data !== want.read_data)
				log_miss("read_data", want.read_data, got.read_data);
			if (got.tape_valid !== want.tape_valid)
				log_miss("tape_write_valid", want.tape_valid, got.tape_valid);
			if (got.tape_bit !== want.tape_bit)
				log_miss("tape_write_bit", want.tape_bit, got.tape_bit);
			if (got.screen_blank !== want.screen_blank)
				log_miss("screen_blank", want.screen_blank, got.screen_blank);
			if (got.motor_on !== want.motor_on)
				log_miss("motor_on", want.motor_on, got.motor_on);
		endfunction
	endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for ppi_keyboard_cassette_port_top: random and directed bus/key words.
// Depends on ppi_kcp_pkg and ppi_kcp_tb_pkg; results checked by ppi_access_board.
module tb;
	import ppi_kcp_pkg::*;
	import ppi_kcp_tb_pkg::*;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 200;

	logic       clk              = 1'b0;
	logic       arst_n           = 1'b0;
	logic       in_valid         = 1'b0;
	logic       in_stall;
	logic [1:0] req_type         = '0;
	logic [1:0] port_sel         = '0;
	logic [7:0] write_data       = '0;
	logic [3:0] key_row          = '0;
	logic [7:0] key_bits         = '0;
	logic       tape_in          = 1'b0;
	logic       vblank_in        = 1'b0;
	logic       out_valid;
	logic       out_stall        = 1'b0;
	logic [7:0] read_data;
	logic       tape_write_valid;
	logic       tape_write_bit;
	logic       screen_blank;
	logic       motor_on;
	logic       cfg_valid        = 1'b0;
	logic       cfg_ready;
	logic       cfg_index        = 1'b0;
	logic [7:0] cfg_data         = '0;

	bit steady   = 1'b0; // no idling on either side while set
	bit hold_off = 1'b0; // receiver holds off, with out_stall high, while set

	ppi_access_board board;
	port_result_t    seen_result;

	always #1 clk = ~clk;

	ppi_keyboard_cassette_port_top #(
		.KEY_ROWS(N_KEY_ROWS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.port_sel        (port_sel),
		.write_data      (write_data),
		.key_row         (key_row),
		.key_bits        (key_bits),
		.tape_in         (tape_in),
		.vblank_in       (vblank_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.tape_write_valid(tape_write_valid),
		.tape_write_bit  (tape_write_bit),
		.screen_blank    (screen_blank),
		.motor_on        (motor_on),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	function automatic item_t mk(logic [1:0] req, logic [1:0] sel, logic [7:0] data,
			logic [3:0] row = 4'd0, logic [7:0] bits = 8'hFF);
		item_t w;
		w.req_type   = req;
		w.port_sel   = sel;
		w.write_data = data;
		w.key_row    = row;
		w.key_bits   = bits;
		w.tape_in    = 1'($urandom);
		w.vblank_in  = 1'($urandom);
		return w;
	endfunction

	function automatic item_t random_word(bit blink_heavy);
		item_t      w;
		logic [25:0] raw;
		int         pick;
		raw  = 26'($urandom);
		w    = raw;
		pick = $urandom_range(0, 99);
		if (blink_heavy && pick < 85) begin
			w.req_type      = REQ_WRITE;
			w.port_sel      = PORT_A;
			w.write_data[7] = 1'b1;
		end else if (pick < 8) begin
			// noise: every field random, unused request type included
		end else if (pick < 26) begin
			w.req_type = REQ_LOAD;
			case ($urandom_range(0, 5))
				0: w.key_row = 4'(K_SHIFT_ROW);
				1: w.key_row = 4'(K_AUX_ROW);
				2: w.key_row = 4'(A_SHIFT_ROW);
				3: ;
				default: w.key_row = 4'($urandom_range(0, N_KEY_ROWS - 1));
			endcase
			case ($urandom_range(0, 5))
				0: w.key_bits = SHIFT_CODE_A;
				1: w.key_bits = SHIFT_CODE_K;
				2: w.key_bits = CTRL_CODE_A;
				3: w.key_bits = KEYS_NONE;
				default: ;
			endcase
		end else if (pick < 44) begin
			w.req_type = REQ_WRITE;
			w.port_sel = PORT_A;
			if ($urandom_range(0, 4) != 0)
				w.write_data[3:0] = 4'($urandom_range(0, N_KEY_ROWS - 1));
		end else if (pick < 60) begin
			w.req_type = REQ_READ;
			w.port_sel = PORT_B;
		end else if (pick < 70) begin
			w.req_type = REQ_READ;
			w.port_sel = PORT_C;
		end else if (pick < 86) begin
			w.req_type      = REQ_WRITE;
			w.port_sel      = PORT_CTRL;
			w.write_data[7] = ($urandom_range(0, 7) == 0);
		end else if (pick < 92) begin
			w.req_type = REQ_WRITE;
			w.port_sel = PORT_C;
		end else if (pick < 95) begin
			w.req_type = REQ_WRITE;
			w.port_sel = PORT_B;
		end else begin
			w.req_type = REQ_READ;
			w.port_sel = $urandom_range(0, 1) ? PORT_A : PORT_CTRL;
		end
		return w;
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= w.req_type;
		port_sel   <= w.port_sel;
		write_data <= w.write_data;
		key_row    <= w.key_row;
		key_bits   <= w.key_bits;
		tape_in    <= w.tape_in;
		vblank_in  <= w.vblank_in;
		do @(posedge clk); while (in_stall);
		board.note_word(w);
	endtask

	// stop sending and wait until every queued result is back
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (board.pending() != 0 && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result checker: inputs and outputs sampled before this edge's updates
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_result.read_data    = read_data;
			seen_result.tape_valid   = tape_write_valid;
			seen_result.tape_bit     = tape_write_bit;
			seen_result.screen_blank = screen_blank;
			seen_result.motor_on     = motor_on;
			board.check_word(seen_result);
		end
	end

	// result side: random stalls per word, one long hold-off on request
	initial begin : result_sink
		int n;
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				n = steady ? 0 : $urandom_range(0, 15);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: status reads, set/reset words, tape gating, shift handling
		send_word(mk(REQ_READ,  PORT_CTRL, 8'h00));
		send_word(mk(REQ_READ,  PORT_C,    8'hFF));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_TAPE, 1'b1}));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_TAPE, 1'b0}));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_GATE, 1'b1}));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_GATE, 1'b0}));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_SENSE, 1'b1}));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_TAPE, 1'b1}));
		send_word(mk(REQ_READ,  PORT_C,    8'h00));
		send_word(mk(REQ_WRITE, PORT_CTRL, {4'b0000, PC_SENSE, 1'b1}));
		send_word(mk(REQ_WRITE, PORT_CTRL, 8'h0D)); // selects bit 6: no effect
		send_word(mk(REQ_WRITE, PORT_CTRL, 8'h9B)); // mode word
		send_word(mk(REQ_WRITE, PORT_C,    8'hFF));
		send_word(mk(REQ_WRITE, PORT_B,    8'h00));
		send_word(mk(REQ_LOAD,  PORT_A,    8'h00, 4'(K_SHIFT_ROW), SHIFT_CODE_K));
		send_word(mk(REQ_LOAD,  PORT_A,    8'h00, 4'hF, 8'h00));
		send_word(mk(REQ_WRITE, PORT_A,    8'h85));
		send_word(mk(REQ_READ,  PORT_B,    8'h00));
		send_word(mk(REQ_WRITE, PORT_A,    8'h08));
		send_word(mk(REQ_READ,  PORT_B,    8'h00));
		send_word(mk(REQ_READ,  PORT_B,    8'h00));
		send_word(mk(REQ_WRITE, PORT_A,    8'hFC));
		send_word(mk(REQ_READ,  PORT_B,    8'h00));
		send_word(mk(REQ_UNUSED, PORT_C,   8'hFF, 4'hF, 8'h00));
		send_word(mk(REQ_READ,  PORT_A,    8'h00));

		repeat (180) send_word(random_word(1'b0));
		drain();

		write_reg(CFG_MODEL, 8'h01);
		write_reg(CFG_PRESCALE, 8'hFF);
		steady = 1'b1;
		repeat (100) send_word(random_word(1'b0));
		steady = 1'b0;
		repeat (70) send_word(random_word(1'b0));
		drain();

		// fast prescale so the blink flag gets past its midpoint
		write_reg(CFG_MODEL, 8'h00);
		write_reg(CFG_PRESCALE, 8'h01);
		repeat (380) send_word(random_word(1'b1));
		drain();

		write_reg(CFG_MODEL, 8'h01);
		write_reg(CFG_PRESCALE, 8'($urandom_range(2, 254)));
		repeat (50) send_word(random_word(1'b0));
		hold_off = 1'b1;
		repeat (150) send_word(random_word(1'b0));
		drain();

		if (board.misses == 0 && board.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (board.pending() != 0)
				$display("%0d result words never arrived", board.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
